@@ rtl/core/kmpw_pkg.sv @@
`timescale 1ns / 1ps

package kmpw_pkg;

    // Request codes carried on req_type.
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_END    = 2'd3
    } kmpw_req_t;

    localparam int unsigned SymbolWidth = 8;
    localparam int unsigned TagWidth    = 16;

    // Per-cycle commands shared by every cell of the row.
    typedef struct packed {
        logic clear;   // drop all partial matches
        logic step;    // advance partial matches by one text byte
    } kmpw_cell_ctrl_t;

endpackage

@@ rtl/core/kmpw_cell.sv @@
`timescale 1ns / 1ps

// One pattern position. The cell holds its pattern byte and a flag telling
// whether the pattern prefix ending at this position is a suffix of the text.
module kmpw_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kmpw_pkg::kmpw_cell_ctrl_t       ctrl,
    input  logic                            load,
    input  logic [kmpw_pkg::SymbolWidth-1:0] symbol,
    input  logic                            prev_active,
    input  logic                            keep,
    output logic                            match,
    output logic                            active
);
    import kmpw_pkg::*;

    logic [SymbolWidth-1:0] pat_reg;
    logic                   active_reg;
    logic                   active_next;

    // The prefix through this position matches if the shorter prefix did and
    // this byte equals the incoming text byte.
    assign match  = prev_active && (pat_reg == symbol);
    assign active = active_reg;

    always_comb
    begin
        active_next = active_reg;
        if (ctrl.clear)
        begin
            active_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            active_next = match && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pat_reg <= symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

@@ rtl/core/kmp_word_substring_matcher_unit.sv @@
`timescale 1ns / 1ps

// Substring detector for a stream of words. Each input transaction is one
// request: clear the pattern, append a pattern byte, feed a text byte, or end
// the current word. Only an end-of-word request produces an output
// transaction, carrying found, the echoed tag and the pattern overflow flag.
//
// The pattern lives in a row of cells, one per position. Every cell keeps a
// flag saying whether the pattern prefix ending there is a suffix of the text
// so far; a text byte shifts those flags one cell along, gated by a byte
// compare in each cell. This tracks exactly the set of prefixes the classic
// failure-function walk would visit.
//
// Throughput is one request per cycle while in_ready is high. An end-of-word result appears on the
// output register the cycle after its request is accepted. The output register
// separates the two sides: in_ready stays high while the result register is
// empty or being drained, and drops only while a result waits on a stalled
// receiver. Reset empties the pattern and clears the match, hit, overflow and valid state.
module kmp_word_substring_matcher_unit #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       req_type,
    input  logic [kmpw_pkg::SymbolWidth-1:0] symbol,
    input  logic [kmpw_pkg::TagWidth-1:0]    word_tag,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [kmpw_pkg::TagWidth-1:0]    tag_out,
    output logic                             pattern_overflow
);
    import kmpw_pkg::*;

    localparam int unsigned LenWidth = $clog2(MAX_PATTERN + 1);

    kmpw_req_t            req;
    logic                 accept;
    kmpw_cell_ctrl_t      ctrl;

    logic [LenWidth-1:0]  len_reg;
    logic [LenWidth-1:0]  len_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 found_reg;
    logic [TagWidth-1:0]  tag_reg;
    logic                 povf_reg;

    logic [MAX_PATTERN-1:0] cell_match;
    logic [MAX_PATTERN-1:0] cell_active;
    logic [MAX_PATTERN-1:0] last_sel;
    logic                   full_hit;
    logic                   pattern_full;

    assign req          = kmpw_req_t'(req_type);
    assign in_ready     = !out_valid_reg || out_ready;
    assign accept       = in_valid && in_ready;
    assign pattern_full = (len_reg == LenWidth'(MAX_PATTERN));

    // Text bytes are ignored while the pattern is empty. Ending a word drops
    // the partial matches just as a clear does.
    assign ctrl.step  = accept && (req == REQ_TEXT) && (len_reg != '0);
    assign ctrl.clear = accept && ((req == REQ_CLEAR) || (req == REQ_END));

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic prev_active;
            logic keep;
            logic load;

            if (k == 0)
            begin : g_head
                // The empty prefix always matches.
                assign prev_active = 1'b1;
            end
            else
            begin : g_body
                assign prev_active = cell_active[k-1];
            end

            // A completed whole-pattern match is not carried forward; the
            // search resumes from the longest proper border instead.
            assign keep        = (LenWidth'(k + 1) < len_reg);
            assign load        = accept && (req == REQ_APPEND) && (len_reg == LenWidth'(k));
            assign last_sel[k] = (len_reg == LenWidth'(k + 1));

            kmpw_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .load        (load),
                .symbol      (symbol),
                .prev_active (prev_active),
                .keep        (keep),
                .match       (cell_match[k]),
                .active      (cell_active[k])
            );
        end
    endgenerate

    // The whole pattern is seen when the cell at the last pattern position
    // matches on this byte.
    assign full_hit = |(cell_match & last_sel);

    always_comb
    begin
        len_next       = len_reg;
        hit_next       = hit_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept)
        begin
            unique case (req)
                REQ_CLEAR:
                begin
                    len_next = '0;
                    hit_next = 1'b0;
                    ovf_next = 1'b0;
                end
                REQ_APPEND:
                begin
                    if (pattern_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        len_next = len_reg + LenWidth'(1);
                    end
                end
                REQ_TEXT:
                begin
                    if (ctrl.step && full_hit)
                    begin
                        hit_next = 1'b1;
                    end
                end
                REQ_END:
                begin
                    hit_next       = 1'b0;
                    out_valid_next = 1'b1;
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            hit_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            hit_reg       <= hit_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload is captured only when an end-of-word request is taken.
    always_ff @(posedge clk)
    begin
        if (accept && (req == REQ_END))
        begin
            found_reg <= hit_reg;
            tag_reg   <= word_tag;
            povf_reg  <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign found            = found_reg;
    assign tag_out          = tag_reg;
    assign pattern_overflow = povf_reg;

endmodule

@@ rtl/core/kmpw_checker.sv @@
`timescale 1ns / 1ps

module kmpw_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [1:0]                       req_type,
    input logic [kmpw_pkg::TagWidth-1:0]    word_tag,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             found,
    input logic [kmpw_pkg::TagWidth-1:0]    tag_out,
    input logic                             pattern_overflow
);
    import kmpw_pkg::*;

    logic in_acc;
    logic in_end;
    logic in_clear;

    assign in_acc   = in_valid && in_ready;
    assign in_end   = in_acc && (req_type == REQ_END);
    assign in_clear = in_acc && (req_type == REQ_CLEAR);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tag_out) && $stable(found)
            && $stable(pattern_overflow))
        else $error("result changed while stalled");

    // An accepted end of word shows its result, with its tag, in the following cycle.
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_end |=> out_valid && (tag_out == $past(word_tag)))
        else $error("end of word did not produce its result");

    // A result only ever appears because an end of word was taken.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_end))
        else $error("result without end of word");

    // An end of word taken right after a clear sees an empty pattern, so it reports neither a match nor an overflow.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_clear ##1 in_end |=> !found && !pattern_overflow)
        else $error("match or overflow reported for an empty pattern");

endmodule

bind kmp_word_substring_matcher_unit kmpw_checker u_kmpw_checker (.*);
